@@ rtl/twmr_pkg.sv @@
`default_nettype none

package twmr_pkg;

    // Generator multipliers and reset words
    localparam logic [31:0] MULT_OLDER  = 32'h1357_9BDE;
    localparam logic [31:0] MULT_NEWER  = 32'h9876_5432;
    localparam logic [31:0] RESET_OLDER = 32'h0000_1000;
    localparam logic [31:0] RESET_NEWER = 32'h0000_5555;

    // Field widths
    localparam int WORD_W = 32;
    localparam int POS_W  = 31;
    localparam int FRAC_W = 24;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One generated word together with the bound it is reduced by
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] limit;
    } entry_t;

    // Producer side of the queue
    typedef struct packed {
        logic   push;
        entry_t entry;
    } queue_wr_t;

    // Consumer side of the queue
    typedef struct packed {
        logic   empty;
        entry_t entry;
    } queue_rd_t;

endpackage

`default_nettype wire

@@ rtl/twmr_in_if.sv @@
`default_nettype none

interface twmr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

`default_nettype wire

@@ rtl/twmr_out_if.sv @@
`default_nettype none

interface twmr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] raw_value;
    logic        [30:0] positive_value;
    logic        [31:0] bounded_value;
    logic signed [24:0] signed_fraction;
    logic               divide_error;

    modport source (
        output valid, output raw_value, output positive_value,
        output bounded_value, output signed_fraction, output divide_error,
        input ready
    );
    modport sink (
        input valid, input raw_value, input positive_value,
        input bounded_value, input signed_fraction, input divide_error,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/twmr_front.sv @@
`default_nettype none

module twmr_front
    import twmr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    twmr_in_if.sink   draw,
    input  wire logic queue_full,
    output queue_wr_t queue_wr
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_PUSH = 1'b1;

    logic              state_reg, state_next;
    logic [WORD_W-1:0] older_reg, older_next;
    logic [WORD_W-1:0] newer_reg, newer_next;
    logic [WORD_W-1:0] prod_older_reg;
    logic [WORD_W-1:0] prod_newer_reg;
    logic [WORD_W-1:0] limit_reg;
    logic [WORD_W-1:0] word;
    logic              accept;
    logic              push;

    assign draw.ready = (state_reg == S_IDLE);
    assign accept     = draw.valid && draw.ready;
    assign push       = (state_reg == S_PUSH) && !queue_full;

    // Combine the registered products into the new word
    assign word = {{4{prod_older_reg[WORD_W-1]}}, prod_older_reg[WORD_W-1:4]}
                  + prod_newer_reg + WORD_W'(1);

    assign queue_wr.push        = push;
    assign queue_wr.entry.word  = word;
    assign queue_wr.entry.limit = limit_reg;

    // Sequence accept and push
    always_comb
    begin
        state_next = state_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (push)
                begin
                    older_next = newer_reg;
                    newer_next = word;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            older_reg <= RESET_OLDER;
            newer_reg <= RESET_NEWER;
        end
        else
        begin
            state_reg <= state_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
        end
    end

    // Register both products and the bound of the accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_older_reg <= WORD_W'(older_reg * MULT_OLDER);
            prod_newer_reg <= WORD_W'(newer_reg * MULT_NEWER);
            limit_reg      <= draw.limit;
        end
    end

endmodule

`default_nettype wire

@@ rtl/twmr_queue.sv @@
`default_nettype none

module twmr_queue
    import twmr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire queue_wr_t  queue_wr,
    output logic            full,
    input  wire logic       pop,
    output queue_rd_t       queue_rd
);

    entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full           = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign queue_rd.empty = (count_reg == '0);
    assign queue_rd.entry = mem[rd_ptr_reg];
    assign do_push        = queue_wr.push && !full;
    assign do_pop         = pop && !queue_rd.empty;

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= queue_wr.entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/twmr_back.sv @@
`default_nettype none

module twmr_back
    import twmr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire queue_rd_t queue_rd,
    output logic           pop,
    twmr_out_if.source     result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int CNT_W = $clog2(POS_W);

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] limit_reg;
    logic [POS_W-1:0]  dividend_reg;
    logic [WORD_W-1:0] rem_reg;
    logic              err_reg;
    logic              valid_reg;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] rem_step;
    logic              out_free;
    logic              load_out;
    logic [FRAC_W:0]   frac_mag;

    assign out_free = !valid_reg || result.ready;
    assign pop      = (state_reg == S_IDLE) && !queue_rd.empty;
    assign load_out = (state_reg == S_DONE) && out_free;

    // One restoring step of the remainder
    assign rem_shift = {rem_reg, dividend_reg[POS_W-1]};
    assign diff      = rem_shift - {1'b0, limit_reg};
    assign rem_step  = diff[WORD_W] ? rem_shift[WORD_W-1:0] : diff[WORD_W-1:0];

    assign frac_mag = {1'b0, word_reg[FRAC_W-1:0]};

    // Sequence pop, reduction and hand-off
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = (queue_rd.entry.limit == '0) ? S_DONE : S_DIV;
                end
            end
            S_DIV:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the popped beat, then shift one dividend bit a cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg     <= queue_rd.entry.word;
            limit_reg    <= queue_rd.entry.limit;
            dividend_reg <= queue_rd.entry.word[POS_W-1:0];
            rem_reg      <= '0;
            err_reg      <= (queue_rd.entry.limit == '0);
            count_reg    <= CNT_W'(POS_W - 1);
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg      <= rem_step;
            dividend_reg <= {dividend_reg[POS_W-2:0], 1'b0};
            count_reg    <= count_reg - CNT_W'(1);
        end
    end

    // Drive the output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result.raw_value      <= $signed(word_reg);
            result.positive_value <= word_reg[POS_W-1:0];
            result.bounded_value  <= rem_reg;
            result.divide_error   <= err_reg;
            result.signed_fraction <= word_reg[WORD_W-1]
                                      ? $signed((FRAC_W+1)'(0) - frac_mag)
                                      : $signed(frac_mag);
        end
    end

    assign result.valid = valid_reg;

endmodule

`default_nettype wire

@@ rtl/two_word_multiply_random_core.sv @@
// Two-word multiplicative random generator.
//
// Channels: "draw" takes one beat per draw carrying the exclusive bound
// (limit). "result" returns one beat per draw: the raw new word, the word
// with its sign bit cleared, that value modulo limit, a signed 25-bit
// fraction (16777216 means 1.0) and a divide error flag for a zero limit.
// Both channels use valid/ready; a beat moves when both are high.
//
// Throughput is set by the bit-serial remainder unit in the back end,
// which retires one dividend bit per cycle over 31 bits and pops a new
// draw only once it is idle. The front end advances the generator with
// two registered multiplies and parks words in a two-entry queue, so up
// to five draws may be in flight while the receiver stalls.
//
// Reset: the generator words return to 0x00001000 and 0x00005555, the
// queue empties and no result is pending. A stalled receiver holds the
// result register; the back end then waits and the queue fills, after
// which the front end accepts one more draw and then holds draw.ready low.
`default_nettype none

module two_word_multiply_random_core
    import twmr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    twmr_in_if.sink    draw,
    twmr_out_if.source result
);

    queue_wr_t queue_wr;
    queue_rd_t queue_rd;
    logic      queue_full;
    logic      pop;

    twmr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .draw       (draw),
        .queue_full (queue_full),
        .queue_wr   (queue_wr)
    );

    twmr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .queue_wr (queue_wr),
        .full     (queue_full),
        .pop      (pop),
        .queue_rd (queue_rd)
    );

    twmr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .queue_rd (queue_rd),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ tb/tb_two_word_multiply_random_core.sv @@
`timescale 1ns / 1ps

module tb_two_word_multiply_random_core;
    import twmr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_DRAWS  = 880;
    localparam int STREAM_DRAWS  = 40;

    // Generator words after reset
    localparam logic [31:0] SEED_OLDER = 32'h0000_1000;
    localparam logic [31:0] SEED_NEWER = 32'h0000_5555;

    // Expected views of one generated word
    typedef struct {
        logic signed [31:0] raw;
        logic        [30:0] positive;
        logic        [31:0] bounded;
        logic signed [24:0] fraction;
        logic               div_err;
    } draw_view_t;

    logic clk;
    logic rst_n;

    twmr_in_if  draw_if ();
    twmr_out_if result_if ();

    two_word_multiply_random_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .draw   (draw_if),
        .result (result_if)
    );

    logic [31:0] gen_older;
    logic [31:0] gen_newer;
    draw_view_t  pending_views[$];

    int  cycle_count;
    int  mismatch_count;
    bit  sender_idle_en;
    bit  receiver_idle_en;
    int  hold_cycles;
    int  stall_left;

    // Clock: 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the generator and work out every view of the new word
    function automatic draw_view_t advance_generator(input logic [31:0] bound);
        logic [31:0] older_prod;
        logic [31:0] older_shifted;
        logic [31:0] newer_prod;
        logic [31:0] next_word;
        logic [24:0] magnitude;
        draw_view_t  v;
        older_prod    = gen_older * MULT_OLDER;
        older_shifted = $signed(older_prod) >>> 4;
        newer_prod    = gen_newer * MULT_NEWER;
        next_word     = older_shifted + newer_prod + 32'd1;
        gen_older     = gen_newer;
        gen_newer     = next_word;

        v.raw      = next_word;
        v.positive = next_word[30:0];
        if (bound == 32'd0)
        begin
            v.bounded = 32'd0;
            v.div_err = 1'b1;
        end
        else
        begin
            v.bounded = {1'b0, next_word[30:0]} % bound;
            v.div_err = 1'b0;
        end
        magnitude  = {1'b0, next_word[23:0]};
        v.fraction = next_word[31] ? (25'd0 - magnitude) : magnitude;
        return v;
    endfunction

    // Compare one field, report the first few differences
    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field,
                         want, got);
            mismatch_count++;
        end
    endfunction

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        draw_view_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_views.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("[%0t] result beat with nothing expected: raw %h", $realtime,
                             result_if.raw_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_views.pop_front();
                check_field("raw_value", want.raw, result_if.raw_value);
                check_field("positive_value", {1'b0, want.positive},
                            {1'b0, result_if.positive_value});
                check_field("bounded_value", want.bounded, result_if.bounded_value);
                check_field("signed_fraction", {7'd0, want.fraction},
                            {7'd0, result_if.signed_fraction});
                check_field("divide_error", {31'd0, want.div_err},
                            {31'd0, result_if.divide_error});
            end
        end
    end

    // Drive result ready: a long hold when one is set, else random stall bursts
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            result_if.ready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_if.ready = 1'b0;
        end
        else if (receiver_idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            result_if.ready = 1'b0;
        end
        else
        begin
            result_if.ready = 1'b1;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one draw beat, called at a falling edge, returns at a falling edge
    task automatic send_draw(input logic [31:0] bound);
        int gap;
        if (sender_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            draw_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        draw_if.valid = 1'b1;
        draw_if.limit = bound;
        do
            @(posedge clk);
        while (!draw_if.ready);
        pending_views.push_back(advance_generator(bound));
        @(negedge clk);
    endtask

    // Switch idling between edges so the ready process sees a stable value
    task automatic set_idling(input bit sender_on, input bit receiver_on);
        @(posedge clk);
        sender_idle_en   = sender_on;
        receiver_idle_en = receiver_on;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_limit();
        logic [31:0] bound;
        case ($urandom_range(0, 9))
            0: bound = 32'd0;
            1: bound = $urandom_range(1, 16);
            2: bound = $urandom_range(1, 65535);
            3: bound = 32'h7FFF_FFFF - $urandom_range(0, 255);
            4: bound = 32'h8000_0000 | $urandom;
            5: bound = 32'd1 << $urandom_range(0, 31);
            default: bound = $urandom;
        endcase
        return bound;
    endfunction

    task automatic test_limit_extremes();
        logic [31:0] bounds[10];
        bounds = '{32'd1, 32'd2, 32'd3, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd7};
        foreach (bounds[i])
            send_draw(bounds[i]);
    endtask

    // Zero bound: flag set, bounded view 0, generator still advances
    task automatic test_zero_limit();
        repeat (3) send_draw(32'd0);
        send_draw(32'd5);
        send_draw(32'd0);
    endtask

    task automatic test_single_bit_limits();
        for (int b = 4; b < 32; b += 4)
            send_draw(32'd1 << b);
    endtask

    // Hold the receiver while draws keep coming so the input stalls
    task automatic test_backpressure();
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        @(negedge clk);
        repeat (10) send_draw(pick_limit());
    endtask

    task automatic test_random_draws();
        repeat (RANDOM_DRAWS) send_draw(pick_limit());
    endtask

    // Back-to-back draws with no idling on either side
    task automatic test_streaming();
        set_idling(1'b0, 1'b0);
        repeat (STREAM_DRAWS) send_draw(pick_limit());
    endtask

    initial
    begin
        rst_n            = 1'b0;
        draw_if.valid    = 1'b0;
        draw_if.limit    = 32'd0;
        result_if.ready  = 1'b0;
        gen_older        = SEED_OLDER;
        gen_newer        = SEED_NEWER;
        cycle_count      = 0;
        mismatch_count   = 0;
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
        hold_cycles      = 0;
        stall_left       = 0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_idling(1'b1, 1'b1);
        test_limit_extremes();
        test_zero_limit();
        test_single_bit_limits();
        test_backpressure();
        test_random_draws();
        test_streaming();
        draw_if.valid = 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_views.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/twmr_pkg.sv
rtl/twmr_in_if.sv
rtl/twmr_out_if.sv
rtl/twmr_front.sv
rtl/twmr_queue.sv
rtl/twmr_back.sv
rtl/two_word_multiply_random_core.sv
tb/tb_two_word_multiply_random_core.sv
